// File: hdl/aso_pkg.sv
// ----------------------------------------------------------------------------
// aso_pkg
// Shared types and constants of the segment overlap counter: transaction
// payloads, the classified command passed from front to back, grid geometry.
// ----------------------------------------------------------------------------
package aso_pkg;

    // geometry and widths
    localparam int COORD_W    = 10;
    localparam int GRID_SIDE  = 1024;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CELL_W     = 2;
    localparam int TOTAL_W    = 21;

    localparam logic [CELL_W-1:0]  CELL_MAX     = '1;
    localparam logic [CELL_W-1:0]  CELL_OVERLAP = CELL_W'(2);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int PTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

    // input transaction: one segment
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } seg_t;

    // output transaction: running overlap total and diagonal flag
    typedef struct packed {
        logic [TOTAL_W-1:0] overlap_cells;
        logic               segment_ignored;
    } res_t;

    // classified segment: walk index from lo to hi along one axis
    typedef struct packed {
        logic               ignored;
        logic               horiz;
        logic [COORD_W-1:0] fixed;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } cmd_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK,
        BK_FINISH
    } back_state_t;

    // coordinate lies on the grid
    function automatic logic in_grid(input logic [COORD_W-1:0] v);
        return int'(v) < GRID_SIDE;
    endfunction

endpackage

// File: hdl/axis_segment_overlap_counter.sv
// ----------------------------------------------------------------------------
// axis_segment_overlap_counter
// Counts grid cells covered by two or more axis-aligned line segments.
// ----------------------------------------------------------------------------
// Input channel seg (seg_valid/seg_ready) carries one segment per transaction
// as two end points on a 1024 by 1024 grid. Output channel res
// (res_valid/res_ready) returns one transaction per segment, in order: the
// running count of cells covered at least twice, and a flag set for a
// diagonal segment, which is not drawn.
// A segment of n cells is walked one cell per cycle through a pipelined
// read-modify-write of the coverage memory; res_valid rises as the last
// cell is written back, and for a diagonal segment as it is picked up.
// The back end takes a new segment only once the previous walk is done
// and the output register is empty; the coverage memory has a single read
// port and a single write port.
// After reset the coverage memory is swept to zero, one cell per cycle,
// GRID_SIDE * GRID_SIDE = 1048576 cells in all; seg_ready stays low until
// the sweep is done. When the receiver stalls, the result waits in the output
// register and no further segment is walked; a two-entry command queue and
// the front holding register take up to three more segments before
// seg_ready drops.
// ----------------------------------------------------------------------------
module axis_segment_overlap_counter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_ready,
    input  aso_pkg::seg_t seg,
    output logic          res_valid,
    input  logic          res_ready,
    output aso_pkg::res_t res
);

    logic          clear_done;
    logic          push_valid;
    logic          push_ready;
    aso_pkg::cmd_t push_cmd;
    logic          cmd_valid;
    logic          cmd_ready;
    aso_pkg::cmd_t cmd;

    // front: accept and classify
    aso_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg),
        .clear_done (clear_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    aso_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    // back: cell walk, coverage memory, result register
    aso_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .clear_done (clear_done),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

// File: hdl/aso_front.sv
// ----------------------------------------------------------------------------
// aso_front
// Accepts segment transactions and classifies them as vertical, horizontal
// or diagonal; holds one classified command until the queue takes it.
// ----------------------------------------------------------------------------
module aso_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_ready,
    input  aso_pkg::seg_t seg,
    input  logic          clear_done,
    output logic          push_valid,
    input  logic          push_ready,
    output aso_pkg::cmd_t push_cmd
);

    logic          held_reg;
    logic          held_next;
    aso_pkg::cmd_t cmd_reg;
    aso_pkg::cmd_t cmd_next;
    logic          accept;
    logic          vert;
    logic          horiz;
    logic [aso_pkg::COORD_W-1:0] end_a;
    logic [aso_pkg::COORD_W-1:0] end_b;

    // take a new segment when the holding register is free or draining
    assign seg_ready  = clear_done && (!held_reg || push_ready);
    assign accept     = seg_valid && seg_ready;
    assign push_valid = held_reg;
    assign push_cmd   = cmd_reg;

    // classification: vertical wins for a single point
    always_comb
    begin
        vert  = (seg.start_x == seg.end_x);
        horiz = !vert && (seg.start_y == seg.end_y);
        end_a = vert ? seg.start_y : seg.start_x;
        end_b = vert ? seg.end_y   : seg.end_x;
        cmd_next.ignored = !vert && !horiz;
        cmd_next.horiz   = horiz;
        cmd_next.fixed   = vert ? seg.start_x : seg.start_y;
        cmd_next.lo      = (end_a < end_b) ? end_a : end_b;
        cmd_next.hi      = (end_a < end_b) ? end_b : end_a;
        if (accept)
            held_next = 1'b1;
        else if (push_ready)
            held_next = 1'b0;
        else
            held_next = held_reg;
    end

    // holding register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else
            held_reg <= held_next;
    end

    // holding register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

// File: hdl/aso_cmd_fifo.sv
// ----------------------------------------------------------------------------
// aso_cmd_fifo
// Short queue of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module aso_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  aso_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output aso_pkg::cmd_t pop_cmd
);

    aso_pkg::cmd_t                entries [aso_pkg::CMD_DEPTH];
    logic [aso_pkg::PTR_W-1:0]    wr_ptr_reg;
    logic [aso_pkg::PTR_W-1:0]    wr_ptr_next;
    logic [aso_pkg::PTR_W-1:0]    rd_ptr_reg;
    logic [aso_pkg::PTR_W-1:0]    rd_ptr_next;
    logic [aso_pkg::CNT_W-1:0]    count_reg;
    logic [aso_pkg::CNT_W-1:0]    count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != aso_pkg::CNT_W'(aso_pkg::CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == aso_pkg::PTR_W'(aso_pkg::CMD_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == aso_pkg::PTR_W'(aso_pkg::CMD_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + aso_pkg::CNT_W'(do_push) - aso_pkg::CNT_W'(do_pop);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hdl/aso_back.sv
// ----------------------------------------------------------------------------
// aso_back
// Walks each command over its cells with a pipelined read-modify-write of
// the coverage memory, keeps the overlap total and registers the result.
// Also sweeps the coverage memory to zero after reset.
// ----------------------------------------------------------------------------
module aso_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  aso_pkg::cmd_t cmd,
    output logic          clear_done,
    output logic          res_valid,
    input  logic          res_ready,
    output aso_pkg::res_t res
);

    // coverage memory
    logic [aso_pkg::CELL_W-1:0] cov_mem [aso_pkg::CELL_COUNT];

    aso_pkg::back_state_t         state_reg;
    aso_pkg::back_state_t         state_next;
    logic [aso_pkg::ADDR_W-1:0]   clr_cnt_reg;
    logic [aso_pkg::ADDR_W-1:0]   clr_cnt_next;
    aso_pkg::cmd_t                cur_reg;
    aso_pkg::cmd_t                cur_next;
    logic [aso_pkg::COORD_W-1:0]  k_reg;
    logic [aso_pkg::COORD_W-1:0]  k_next;
    logic                         b_valid_reg;
    logic                         b_in_grid_reg;
    logic [aso_pkg::ADDR_W-1:0]   b_addr_reg;
    logic [aso_pkg::CELL_W-1:0]   rdata_reg;
    logic [aso_pkg::TOTAL_W-1:0]  total_reg;
    logic [aso_pkg::TOTAL_W-1:0]  total_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    aso_pkg::res_t                out_data_reg;
    aso_pkg::res_t                out_data_next;

    logic                         a_fire;
    logic                         clearing;
    logic                         k_last;
    logic [aso_pkg::COORD_W-1:0]  a_col;
    logic [aso_pkg::COORD_W-1:0]  a_row;
    logic                         a_in_grid;
    logic [31:0]                  a_addr_full;
    logic [aso_pkg::ADDR_W-1:0]   a_addr;
    logic                         bump;
    logic [aso_pkg::CELL_W-1:0]   cell_new;
    logic                         wr_en;
    logic [aso_pkg::ADDR_W-1:0]   wr_addr;
    logic [aso_pkg::CELL_W-1:0]   wr_data;

    assign clear_done = (state_reg != aso_pkg::BK_CLEAR);
    assign res_valid  = out_valid_reg;
    assign res        = out_data_reg;

    // read stage: cell address of the current walk index
    always_comb
    begin
        a_col       = cur_reg.horiz ? k_reg : cur_reg.fixed;
        a_row       = cur_reg.horiz ? cur_reg.fixed : k_reg;
        a_in_grid   = aso_pkg::in_grid(a_col) && aso_pkg::in_grid(a_row);
        a_addr_full = 32'(a_row) * 32'(aso_pkg::GRID_SIDE) + 32'(a_col);
        a_addr      = a_addr_full[aso_pkg::ADDR_W-1:0];
        k_last      = (k_reg == cur_reg.hi);
    end

    // update stage: saturating cell increment and overlap total
    always_comb
    begin
        bump     = b_valid_reg && b_in_grid_reg && (rdata_reg != aso_pkg::CELL_MAX);
        cell_new = rdata_reg + 1'b1;
        total_next = total_reg;
        if (bump && (cell_new == aso_pkg::CELL_OVERLAP) && (total_reg != aso_pkg::TOTAL_MAX))
            total_next = total_reg + 1'b1;
        wr_en   = clearing || bump;
        wr_addr = clearing ? clr_cnt_reg : b_addr_reg;
        wr_data = clearing ? '0 : cell_new;
    end

    // sequencer: clear sweep, command pickup, walk, result
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_data_next  = out_data_reg;
        cmd_ready      = 1'b0;
        a_fire         = 1'b0;
        clearing       = 1'b0;
        unique case (state_reg)
            aso_pkg::BK_CLEAR:
            begin
                clearing     = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == aso_pkg::ADDR_W'(aso_pkg::CELL_COUNT - 1))
                    state_next = aso_pkg::BK_IDLE;
            end
            aso_pkg::BK_IDLE:
            begin
                if (!out_valid_reg)
                begin
                    cmd_ready = 1'b1;
                    if (cmd_valid)
                    begin
                        if (cmd.ignored)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{overlap_cells: total_reg,
                                               segment_ignored: 1'b1};
                        end
                        else
                        begin
                            cur_next   = cmd;
                            k_next     = cmd.lo;
                            state_next = aso_pkg::BK_WALK;
                        end
                    end
                end
            end
            aso_pkg::BK_WALK:
            begin
                a_fire = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_last)
                    state_next = aso_pkg::BK_FINISH;
            end
            aso_pkg::BK_FINISH:
            begin
                // last cell is in the update stage this cycle
                out_valid_next = 1'b1;
                out_data_next  = '{overlap_cells: total_next, segment_ignored: 1'b0};
                state_next     = aso_pkg::BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aso_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            b_valid_reg   <= a_fire;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        b_in_grid_reg <= a_in_grid;
        b_addr_reg    <= a_addr;
        out_data_reg  <= out_data_next;
    end

    // memory read port
    always_ff @(posedge clk)
    begin
        if (a_fire)
            rdata_reg <= cov_mem[a_addr];
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            cov_mem[wr_addr] <= wr_data;
    end

endmodule
